/* hw/rtl/assert_macros.svh */
// assertion helpers, clocked with asynchronous active-low reset disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* hw/rtl/spbt_pkg.sv */
`timescale 1ns / 1ps

package spbt_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int DATA_W        = 16;
  localparam int WORD_W        = 3 * DATA_W;
  localparam int NREL_W        = $clog2(MAX_RESULTS + 1);
  localparam int PTR_W         = $clog2(MAX_RESULTS);

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_ASSIGN = 1'b1;

  localparam logic [3:0] FREE_NONE = 4'hF;
  localparam logic [3:0] BUSY_SAT  = 4'hF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_WB,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic start;
    logic rd_issue;
    logic acc_step;
    logic wb_step;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic need_rd;
    logic scan_last;
    logic out_last;
  } status_t;

endpackage

/* hw/rtl/server_pool_busy_timer_unit.sv */
`timescale 1ns / 1ps

// Pool of NUM_SLOTS server slots with per-slot countdown. An item is taken only when the block
// is idle. After the accept cycle every slot is visited once in order by a controller that walks
// the slot memory: a free slot, or any slot on an assign, is handled in the scan-read state; a
// busy slot on a tick also passes the write-back state (registered memory read, then decrement
// and write back or release). The results, at least one per item, are then presented one per
// cycle while the output side takes them. The slot memory needs no clearing after reset.

module server_pool_busy_timer_unit import spbt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [2:0]        slot_index_i,
  input  logic [15:0]       customer_number_i,
  input  logic [15:0]       transaction_time_i,
  input  logic [15:0]       arrival_time_i,
  input  logic [15:0]       waiting_time_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              departed_o,
  output logic [2:0]        departed_slot_o,
  output logic [15:0]       departed_customer_o,
  output logic [15:0]       departure_time_o,
  output logic signed [3:0] free_slot_o,
  output logic [3:0]        busy_count_o,
  output logic              last_o
);

  cmd_t    cmd;
  status_t status;

  spbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  spbt_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .kind_i              (kind_i),
    .slot_index_i        (slot_index_i),
    .customer_number_i   (customer_number_i),
    .transaction_time_i  (transaction_time_i),
    .arrival_time_i      (arrival_time_i),
    .waiting_time_i      (waiting_time_i),
    .departed_o          (departed_o),
    .departed_slot_o     (departed_slot_o),
    .departed_customer_o (departed_customer_o),
    .departure_time_o    (departure_time_o),
    .free_slot_o         (free_slot_o),
    .busy_count_o        (busy_count_o),
    .last_o              (last_o)
  );

endmodule

/* hw/rtl/spbt_ram.sv */
`timescale 1ns / 1ps

module spbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/spbt_ctrl.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module spbt_ctrl import spbt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (status_i.need_rd) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_SCAN_WB;
        end else begin
          cmd_o.acc_step = 1'b1;
          if (status_i.scan_last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SCAN_WB: begin
        cmd_o.wb_step = 1'b1;
        state_d       = status_i.scan_last ? ST_EMIT : ST_SCAN_RD;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_next = 1'b1;
          if (status_i.out_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o, "accept during emit")
  `ASSERT_CLK(a_wb_after_rd, clk_i, rst_ni, (state_q == ST_SCAN_WB) |-> ($past(state_q) == ST_SCAN_RD), "write-back without read")
  `ASSERT_CLK(a_emit_done, clk_i, rst_ni, (out_valid_o && out_ready_i && status_i.out_last) |=> in_ready_o, "no return to idle after last transfer")

endmodule

/* hw/rtl/spbt_datapath.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module spbt_datapath import spbt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic               kind_i,
  input  logic [2:0]         slot_index_i,
  input  logic [15:0]        customer_number_i,
  input  logic [15:0]        transaction_time_i,
  input  logic [15:0]        arrival_time_i,
  input  logic [15:0]        waiting_time_i,
  output logic               departed_o,
  output logic [2:0]         departed_slot_o,
  output logic [15:0]        departed_customer_o,
  output logic [15:0]        departure_time_o,
  output logic signed [3:0]  free_slot_o,
  output logic [3:0]         busy_count_o,
  output logic               last_o
);

  logic [NUM_SLOTS-1:0] busy_q;
  logic                 tick_q;
  logic [SLOT_W-1:0]    scan_idx_q;
  logic [NREL_W-1:0]    nrel_q;
  logic [PTR_W-1:0]     ptr_q;
  logic [3:0]           bc_q;
  logic [3:0]           fs_q;
  logic                 fs_found_q;

  logic [2:0]           rel_slot_q [MAX_RESULTS];
  logic [DATA_W-1:0]    rel_cust_q [MAX_RESULTS];
  logic [DATA_W-1:0]    rel_dep_q  [MAX_RESULTS];

  logic                 assign_ok;
  logic [DATA_W-1:0]    rem_init;
  logic [DATA_W-1:0]    dep_init;
  logic [WORD_W-1:0]    rdata;
  logic [DATA_W-1:0]    rd_rem;
  logic [DATA_W-1:0]    rd_cust;
  logic [DATA_W-1:0]    rd_dep;
  logic [DATA_W-1:0]    rem_next;
  logic                 release_hit;
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 cur_busy;
  logic                 mark_free;
  logic                 mark_busy;
  logic [3:0]           fs_code;

  assign assign_ok = (kind_i == KIND_ASSIGN) && (32'(slot_index_i) < NUM_SLOTS);
  assign rem_init  = (transaction_time_i == '0) ? DATA_W'(1) : transaction_time_i;
  assign dep_init  = arrival_time_i + waiting_time_i + transaction_time_i;

  assign {rd_rem, rd_cust, rd_dep} = rdata;
  assign rem_next    = (rd_rem != '0) ? rd_rem - DATA_W'(1) : rd_rem;
  assign release_hit = (rem_next == '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_idx_q;
    ram_wdata = {rem_next, rd_cust, rd_dep};
    if (cmd_i.start) begin
      ram_we    = assign_ok;
      ram_waddr = SLOT_W'(slot_index_i);
      ram_wdata = {rem_init, customer_number_i, dep_init};
    end else if (cmd_i.wb_step) begin
      ram_we = !release_hit;
    end
  end

  spbt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_SLOTS),
    .AW    (SLOT_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (scan_idx_q),
    .rdata_o (rdata)
  );

  assign cur_busy  = busy_q[scan_idx_q];
  assign mark_free = (cmd_i.acc_step && !cur_busy) || (cmd_i.wb_step && release_hit);
  assign mark_busy = (cmd_i.acc_step && cur_busy) || (cmd_i.wb_step && !release_hit);
  assign fs_code   = (32'(scan_idx_q) <= 7) ? 4'(scan_idx_q) : FREE_NONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= '0;
      tick_q     <= 1'b0;
      scan_idx_q <= '0;
      nrel_q     <= '0;
      ptr_q      <= '0;
      bc_q       <= '0;
      fs_q       <= FREE_NONE;
      fs_found_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        tick_q     <= (kind_i == KIND_TICK);
        scan_idx_q <= '0;
        nrel_q     <= '0;
        ptr_q      <= '0;
        bc_q       <= '0;
        fs_q       <= FREE_NONE;
        fs_found_q <= 1'b0;
        if (assign_ok) begin
          busy_q[SLOT_W'(slot_index_i)] <= 1'b1;
        end
      end
      if (cmd_i.acc_step || cmd_i.wb_step) begin
        scan_idx_q <= scan_idx_q + SLOT_W'(1);
      end
      if (mark_busy && (bc_q != BUSY_SAT)) begin
        bc_q <= bc_q + 4'd1;
      end
      if (mark_free && !fs_found_q) begin
        fs_found_q <= 1'b1;
        fs_q       <= fs_code;
      end
      if (cmd_i.wb_step && release_hit) begin
        busy_q[scan_idx_q] <= 1'b0;
        if (nrel_q < NREL_W'(MAX_RESULTS)) begin
          nrel_q <= nrel_q + NREL_W'(1);
        end
      end
      if (cmd_i.emit_next) begin
        ptr_q <= ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb_step && release_hit && (nrel_q < NREL_W'(MAX_RESULTS))) begin
      rel_slot_q[nrel_q[PTR_W-1:0]] <= 3'(scan_idx_q);
      rel_cust_q[nrel_q[PTR_W-1:0]] <= rd_cust;
      rel_dep_q[nrel_q[PTR_W-1:0]]  <= rd_dep;
    end
  end

  assign status_o.need_rd   = tick_q && cur_busy;
  assign status_o.scan_last = (32'(scan_idx_q) == NUM_SLOTS - 1);
  assign status_o.out_last  = last_o;

  assign departed_o          = (nrel_q != '0);
  assign departed_slot_o     = departed_o ? rel_slot_q[ptr_q] : 3'd0;
  assign departed_customer_o = departed_o ? rel_cust_q[ptr_q] : '0;
  assign departure_time_o    = departed_o ? rel_dep_q[ptr_q] : '0;
  assign free_slot_o         = fs_q;
  assign busy_count_o        = bc_q;
  assign last_o              = !departed_o || (NREL_W'(ptr_q) == nrel_q - NREL_W'(1));

  `ASSERT_NEVER(a_nrel_bound, clk_i, rst_ni, nrel_q > NREL_W'(MAX_RESULTS), "release list overrun")
  `ASSERT_CLK(a_busy_rem_live, clk_i, rst_ni, cmd_i.wb_step |-> (rd_rem != '0), "busy slot with zero countdown")
  `ASSERT_CLK(a_wb_slot_busy, clk_i, rst_ni, cmd_i.wb_step |-> cur_busy, "write-back on free slot")

endmodule

/* tb/server_pool_busy_timer_unit_test.sv */
`timescale 1ns / 1ps

module server_pool_busy_timer_unit_test import spbt_pkg::*;;

  typedef struct packed {
    logic        kind;
    logic [2:0]  slot;
    logic [15:0] customer;
    logic [15:0] service;
    logic [15:0] arrival;
    logic [15:0] waiting;
  } request_t;

  typedef struct packed {
    logic              departed;
    logic [2:0]        slot;
    logic [15:0]       customer;
    logic [15:0]       dep_time;
    logic signed [3:0] free_slot;
    logic [3:0]        busy_count;
    logic              last;
  } departure_t;

  class pool_scoreboard;
    bit          busy[8];
    logic [15:0] remaining[8];
    logic [15:0] customer[8];
    logic [15:0] dep_time[8];
    departure_t  departures_q[$];
    int          errors;

    function new();
      foreach (busy[i]) begin
        busy[i] = 1'b0;
        remaining[i] = '0;
        customer[i] = '0;
        dep_time[i] = '0;
      end
      errors = 0;
    endfunction

    function int outstanding();
      return departures_q.size();
    endfunction

    // update the slot pool and queue the departures one request causes
    function void note_request(request_t r);
      int          released[$];
      logic [3:0]  free_code;
      logic [3:0]  busy_total;
      departure_t  d;
      if (r.kind == KIND_ASSIGN) begin
        busy[r.slot] = 1'b1;
        remaining[r.slot] = (r.service == 16'd0) ? 16'd1 : r.service;
        customer[r.slot] = r.customer;
        dep_time[r.slot] = r.arrival + r.waiting + r.service;
      end else begin
        for (int i = 0; i < 8; i++) begin
          if (busy[i]) begin
            if (remaining[i] != 16'd0) remaining[i] = remaining[i] - 16'd1;
            if (remaining[i] == 16'd0) begin
              busy[i] = 1'b0;
              released.push_back(i);
            end
          end
        end
      end
      free_code = FREE_NONE;
      busy_total = '0;
      for (int i = 7; i >= 0; i--) begin
        if (!busy[i]) free_code = 4'(i);
        else busy_total = busy_total + 4'd1;
      end
      if (released.size() == 0) begin
        d = '0;
        d.free_slot = free_code;
        d.busy_count = busy_total;
        d.last = 1'b1;
        departures_q.push_back(d);
      end else begin
        foreach (released[k]) begin
          d.departed = 1'b1;
          d.slot = 3'(released[k]);
          d.customer = customer[released[k]];
          d.dep_time = dep_time[released[k]];
          d.free_slot = free_code;
          d.busy_count = busy_total;
          d.last = (k == released.size() - 1);
          departures_q.push_back(d);
        end
      end
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_result(departure_t got);
      departure_t exp;
      if (departures_q.size() == 0) begin
        report($sformatf("result with nothing expected: %p", got));
        return;
      end
      exp = departures_q.pop_front();
      if (got.departed !== exp.departed)
        report($sformatf("departed %b, expected %b", got.departed, exp.departed));
      if (got.slot !== exp.slot)
        report($sformatf("departed_slot %0d, expected %0d", got.slot, exp.slot));
      if (got.customer !== exp.customer)
        report($sformatf("departed_customer %h, expected %h", got.customer, exp.customer));
      if (got.dep_time !== exp.dep_time)
        report($sformatf("departure_time %h, expected %h", got.dep_time, exp.dep_time));
      if (got.free_slot !== exp.free_slot)
        report($sformatf("free_slot %0d, expected %0d", got.free_slot, exp.free_slot));
      if (got.busy_count !== exp.busy_count)
        report($sformatf("busy_count %0d, expected %0d", got.busy_count, exp.busy_count));
      if (got.last !== exp.last)
        report($sformatf("last %b, expected %b", got.last, exp.last));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              kind_i;
  logic [2:0]        slot_index_i;
  logic [15:0]       customer_number_i;
  logic [15:0]       transaction_time_i;
  logic [15:0]       arrival_time_i;
  logic [15:0]       waiting_time_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              departed_o;
  logic [2:0]        departed_slot_o;
  logic [15:0]       departed_customer_o;
  logic [15:0]       departure_time_o;
  logic signed [3:0] free_slot_o;
  logic [3:0]        busy_count_o;
  logic              last_o;

  pool_scoreboard sb = new();
  bit             quiet = 1'b0;
  int             sent = 0;

  server_pool_busy_timer_unit DUT (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .kind_i, .slot_index_i, .customer_number_i,
    .transaction_time_i, .arrival_time_i, .waiting_time_i,
    .out_valid_o, .out_ready_i,
    .departed_o, .departed_slot_o, .departed_customer_o, .departure_time_o,
    .free_slot_o, .busy_count_o, .last_o
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // transfers are observed at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_request({kind_i, slot_index_i, customer_number_i,
                         transaction_time_i, arrival_time_i, waiting_time_i});
      if (out_valid_o && out_ready_i)
        sb.check_result({departed_o, departed_slot_o, departed_customer_o,
                         departure_time_o, free_slot_o, busy_count_o, last_o});
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && (quiet || $urandom_range(99) >= 29);
  end

  task send_item(input logic kind, input logic [2:0] slot, input logic [15:0] cust,
                 input logic [15:0] service, input logic [15:0] arrival,
                 input logic [15:0] waiting);
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    slot_index_i <= slot;
    customer_number_i <= cust;
    transaction_time_i <= service;
    arrival_time_i <= arrival;
    waiting_time_i <= waiting;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent++;
  endtask

  task send_assign(input logic [2:0] slot, input logic [15:0] cust,
                   input logic [15:0] service, input logic [15:0] arrival,
                   input logic [15:0] waiting);
    send_item(KIND_ASSIGN, slot, cust, service, arrival, waiting);
  endtask

  // tick payload is ignored by the block but still toggled
  task send_tick();
    send_item(KIND_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  function logic [15:0] random_service();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) return 16'($urandom_range(0, 6));
    if (pick < 90) return 16'($urandom_range(0, 40));
    return 16'($urandom);
  endfunction

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = KIND_TICK;
    slot_index_i = '0;
    customer_number_i = '0;
    transaction_time_i = '0;
    arrival_time_i = '0;
    waiting_time_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    send_tick();
    send_assign(3'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    send_tick();
    for (int s = 7; s >= 0; s--)
      send_assign(3'(s), 16'(16'h1111 * s), 16'd1, 16'(s * 100), 16'(s));
    send_assign(3'd3, 16'h5A5A, 16'd2, 16'h8000, 16'h7FFF);
    send_tick();
    send_tick();
    send_assign(3'd5, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    send_tick();
    send_assign(3'd5, 16'hA5A5, 16'd3, 16'h1234, 16'h0001);
    repeat (3) send_tick();
    send_assign(3'd2, 16'h8000, 16'd0, 16'hFFF0, 16'h0020);
    send_tick();

    // random part
    while (sent < 310) begin
      quiet = (sent >= 140 && sent < 220);
      if ($urandom_range(99) < 4) begin
        for (int s = 0; s < 8; s++)
          send_assign(3'(s), 16'($urandom), 16'($urandom_range(0, 2)),
                      16'($urandom), 16'($urandom));
      end else if ($urandom_range(99) < 45) begin
        send_tick();
      end else begin
        send_assign(3'($urandom), 16'($urandom), random_service(),
                    16'($urandom), 16'($urandom));
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
